>>> rtl/kdsp_pkg.sv
// Package for the kd-tree shadow photon query block.
// Holds sizes, register addresses, controller states and command/status types.
package kdsp_pkg;
  localparam int STORE_DEPTH = 1024;
  localparam int COORD_BITS  = 16;
  localparam int WALK_DEPTH  = 12;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int RAD_W       = 34;
  localparam int SP_W        = $clog2(WALK_DEPTH + 1);
  localparam int AXIS_W      = 2;
  localparam int ENTRY_W     = 3 * COORD_BITS + AXIS_W + 1;
  localparam int CAP_W       = 11;
  localparam int ADDR_W      = 4;

  localparam logic [ADDR_W-1:0] ADDR_CAPACITY = 4'h0;
  localparam logic [ADDR_W-1:0] ADDR_RADIUS   = 4'h8;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] CLS_LIT    = 2'd0;
  localparam logic [1:0] CLS_SHADOW = 2'd1;
  localparam logic [1:0] CLS_MIXED  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_STORE, ST_NODE, ST_READ, ST_DIST, ST_DECIDE, ST_POP, ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input word
    logic store;     // write photon, bump count
    logic start;     // init walk range
    logic rd;        // read median entry
    logic calc;      // compute distances
    logic decide;    // classify and step the walk
    logic pop;       // pop walk stack
    logic finish;    // latch result word
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_query;
    logic full;
    logic range_ok;  // hi >= lo
    logic stop;      // mixed found
    logic next;      // walk continues at new range
    logic stack_empty;
  } stat_t;

  // median of [lo, hi] in the balanced layout
  function automatic logic [IDX_W+1:0] pick_median(input logic [IDX_W+1:0] lo,
                                                   input logic [IDX_W+1:0] hi);
    logic [IDX_W+1:0] n;
    logic [IDX_W+1:0] m;
    n = hi - lo + 1'b1;
    m = '0;
    for (int i = 0; i <= IDX_W; i++) begin
      if (({2'b00, {(IDX_W){1'b0}}} | ((IDX_W+2)'(1) << i)) * 4 <= n) m = (IDX_W+2)'(1) << (i + 1);
    end
    if (m == '0) m = (IDX_W+2)'(1);
    if (3 * m <= n) return m + m + lo - 1'b1;
    return hi - m + 1'b1;
  endfunction
endpackage

>>> rtl/kdsp_if.sv
// Valid/ready channel interface with a generic payload type.
// Depends on nothing; used for the input and result channels.
interface kdsp_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/kdsp_ctrl.sv
// Controller state machine for the photon store and tree walk.
// Depends on kdsp_pkg.
module kdsp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  kdsp_pkg::stat_t stat,
  output kdsp_pkg::cmd_t  cmd
);
  import kdsp_pkg::*;
  state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_STORE;
      ST_STORE:  state_nxt = stat.is_query ? ST_NODE : ST_DONE;
      ST_NODE:   state_nxt = stat.range_ok ? ST_READ : ST_POP;
      ST_READ:   state_nxt = ST_DIST;
      ST_DIST:   state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (stat.stop) state_nxt = ST_DONE;
        else if (stat.next) state_nxt = ST_NODE;
        else state_nxt = ST_POP;
      end
      ST_POP:    state_nxt = stat.stack_empty ? ST_DONE : ST_NODE;
      ST_DONE:   if (out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_ready  = (state_r == ST_IDLE);
    out_valid = (state_r == ST_DONE);
    case (state_r)
      ST_IDLE:   cmd.load = in_valid;
      ST_STORE:  begin
        cmd.store = !stat.is_query;
        cmd.start = stat.is_query;
      end
      ST_NODE:   cmd.rd = stat.range_ok;
      ST_DIST:   cmd.calc = 1'b1;
      ST_DECIDE: cmd.decide = 1'b1;
      ST_POP:    cmd.pop = 1'b1;
      default:   cmd = '0;
    endcase
  end
endmodule

>>> rtl/kdsp_dp.sv
// Datapath: photon memory, walk stack, distance and compare logic.
// Depends on kdsp_pkg.
module kdsp_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  kdsp_pkg::cmd_t                      cmd,
  output kdsp_pkg::stat_t                     stat,
  input  logic                                in_operation,
  input  logic signed [kdsp_pkg::COORD_BITS-1:0] in_pos_x,
  input  logic signed [kdsp_pkg::COORD_BITS-1:0] in_pos_y,
  input  logic signed [kdsp_pkg::COORD_BITS-1:0] in_pos_z,
  input  logic [kdsp_pkg::AXIS_W-1:0]         in_split_axis,
  input  logic                                in_photon_shadow,
  input  logic [kdsp_pkg::CAP_W-1:0]          capacity_limit,
  input  logic [kdsp_pkg::RAD_W-1:0]          gather_sq_radius,
  output logic                                res_accepted,
  output logic [1:0]                          res_class
);
  import kdsp_pkg::*;
  localparam int IW = IDX_W + 2;            // signed walk index width
  localparam int DW = COORD_BITS + 1;
  localparam int SQ_W = 2 * DW;

  logic [ENTRY_W-1:0] mem [STORE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [2*IW-1:0]    stk [WALK_DEPTH];
  logic [SP_W-1:0]    sp_r;
  logic [CNT_W-1:0]   count_r;

  logic                         op_r, shd_r;
  logic signed [COORD_BITS-1:0] q_r [3];
  logic [AXIS_W-1:0]            ax_r;
  logic signed [IW-1:0]         lo_r, hi_r, md_r;
  logic                         lit_r, shad_r;
  logic [SQ_W+1:0]              dist_r;
  logic [SQ_W-1:0]              d2_r;
  logic signed [DW-1:0]         dax_r;
  logic                         acc_r;
  logic [1:0]                   cls_r;

  // capacity bound
  logic [CNT_W-1:0] lim;
  assign lim = (capacity_limit < CAP_W'(STORE_DEPTH)) ? CNT_W'(capacity_limit)
                                                      : CNT_W'(STORE_DEPTH);

  // median of current range
  logic signed [IW-1:0] md_c;
  assign md_c = pick_median(lo_r, hi_r);

  // unpack the read entry
  logic signed [COORD_BITS-1:0] pc [3];
  logic [AXIS_W-1:0]            p_ax;
  logic                         p_sh;
  assign pc[0] = rd_data_r[ENTRY_W-1 -: COORD_BITS];
  assign pc[1] = rd_data_r[ENTRY_W-1-COORD_BITS -: COORD_BITS];
  assign pc[2] = rd_data_r[ENTRY_W-1-2*COORD_BITS -: COORD_BITS];
  assign p_ax  = rd_data_r[2:1];
  assign p_sh  = rd_data_r[0];

  logic signed [DW-1:0] dk [3];
  logic [SQ_W-1:0]      sq [3];
  logic [1:0]           axs;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dk[k] = DW'(q_r[k]) - DW'(pc[k]);
      sq[k] = SQ_W'(dk[k] * dk[k]);
    end
    axs = (p_ax > 2'd2) ? 2'd2 : p_ax;
  end

  // decide step
  logic found, lit_n, shad_n, d2_gt, d2_lt;
  always_comb begin
    found  = (dist_r < (SQ_W+2)'(gather_sq_radius));
    lit_n  = lit_r  | (found & !shd_r);
    shad_n = shad_r | (found &  shd_r);
    d2_gt  = (RAD_W'(d2_r) > gather_sq_radius);
    d2_lt  = (RAD_W'(d2_r) < gather_sq_radius);
  end

  assign stat.is_query    = op_r;
  assign stat.full        = (count_r >= lim);
  assign stat.range_ok    = (hi_r >= lo_r);
  assign stat.stop        = lit_n & shad_n;
  assign stat.next        = d2_gt | d2_lt;
  assign stat.stack_empty = (sp_r == '0);

  // photon memory
  always_ff @(posedge clk) begin
    if (cmd.store && !stat.full)
      mem[count_r[IDX_W-1:0]] <= {q_r[0], q_r[1], q_r[2], ax_r, shd_r};
    if (cmd.rd) rd_data_r <= mem[md_c[IDX_W-1:0]];
  end

  // walk stack
  always_ff @(posedge clk) begin
    if (cmd.decide && d2_lt && !stat.stop && sp_r < SP_W'(WALK_DEPTH))
      stk[sp_r[$clog2(WALK_DEPTH)-1:0]] <= {md_r + 1'b1, hi_r};
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sp_r    <= '0;
    end else begin
      if (cmd.store && !stat.full) count_r <= count_r + 1'b1;
      if (cmd.start) sp_r <= '0;
      if (cmd.decide && d2_lt && !stat.stop && sp_r < SP_W'(WALK_DEPTH))
        sp_r <= sp_r + 1'b1;
      if (cmd.pop && sp_r != '0) sp_r <= sp_r - 1'b1;
    end
  end

  // payload and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_operation; q_r[0] <= in_pos_x; q_r[1] <= in_pos_y;
      q_r[2] <= in_pos_z; ax_r <= in_split_axis; shd_r <= in_photon_shadow;
    end
    if (cmd.store) begin
      acc_r <= !stat.full; cls_r <= CLS_LIT;
    end
    if (cmd.start) begin
      lo_r <= '0; hi_r <= IW'(count_r) - 1'b1; lit_r <= 1'b0; shad_r <= 1'b0;
      acc_r <= 1'b1;
    end
    if (cmd.rd) md_r <= md_c;
    if (cmd.calc) begin
      dist_r <= (SQ_W+2)'(sq[0]) + (SQ_W+2)'(sq[1]) + (SQ_W+2)'(sq[2]);
      d2_r   <= sq[axs];
      dax_r  <= dk[axs];
      shd_r  <= p_sh;
    end
    if (cmd.decide) begin
      lit_r <= lit_n; shad_r <= shad_n;
      if (d2_gt) begin
        if (dax_r <= 0) hi_r <= md_r - 1'b1;
        else            lo_r <= md_r + 1'b1;
      end else if (d2_lt) hi_r <= md_r - 1'b1;
      if (stat.stop) cls_r <= CLS_MIXED;
    end
    if (cmd.pop && sp_r != '0) begin
      lo_r <= stk[sp_r[$clog2(WALK_DEPTH)-1:0] - 1'b1][2*IW-1:IW];
      hi_r <= stk[sp_r[$clog2(WALK_DEPTH)-1:0] - 1'b1][IW-1:0];
    end
    if (cmd.pop && sp_r == '0)
      cls_r <= (lit_r & shad_r) ? CLS_MIXED : (lit_r ? CLS_LIT : CLS_SHADOW);
  end

  assign res_accepted = acc_r;
  assign res_class    = cls_r;
endmodule

>>> rtl/kd_tree_shadow_photon_query.sv
// Top level of the kd-tree shadow photon query block.
// Depends on kdsp_pkg, kdsp_if, kdsp_ctrl and kdsp_dp.
//
// Usage: each input word is either a photon store or a shadow query.
// A store appends one photon (position, split axis, shadow flag) to the
// photon memory unless the count has reached capacity_limit; the result
// word reports whether it was accepted and class 0. A query walks the
// stored photons as a balanced kd-tree and returns lit, shadowed (also
// when nothing is found) or mixed. One result word follows every input word.
// Sequence: a store passes through intake, write and hand-off; a query
// through intake, setup and hand-off, with node, read, distance and decide
// steps per visited tree node, a pop step per stack pop and a node check
// per empty subrange, using the single read port of the photon memory and
// the shared distance unit. One word is in flight at a time.
// Reset clears the photon count, the walk stack pointer and the
// controller; the photon memory content is left as is. While the
// receiver stalls, the result word is held and no input is taken.
// Registers: capacity_limit at 0x0, gather_sq_radius at 0x8 (64-bit data).
module kd_tree_shadow_photon_query (
  input  logic        clk,
  input  logic        rst_n,
  kdsp_if.sink        in_ch,
  kdsp_if.source      out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [kdsp_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import kdsp_pkg::*;
  cmd_t  cmd;
  stat_t stat;
  logic [CAP_W-1:0] cap_r;
  logic [RAD_W-1:0] rad_r;
  logic             wr;

  // register file
  assign cfg_pready = 1'b1;
  assign wr = cfg_psel & cfg_penable & cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_W'(STORE_DEPTH);
      rad_r <= '0;
    end else if (wr) begin
      if (cfg_paddr == ADDR_CAPACITY) cap_r <= cfg_pwdata[CAP_W-1:0];
      if (cfg_paddr == ADDR_RADIUS)   rad_r <= cfg_pwdata[RAD_W-1:0];
    end
  end
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == ADDR_CAPACITY) cfg_prdata = 64'(cap_r);
    else if (cfg_paddr == ADDR_RADIUS) cfg_prdata = 64'(rad_r);
  end

  kdsp_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat, .cmd
  );

  kdsp_dp u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_operation(in_ch.data.operation),
    .in_pos_x(in_ch.data.pos_x), .in_pos_y(in_ch.data.pos_y),
    .in_pos_z(in_ch.data.pos_z), .in_split_axis(in_ch.data.split_axis),
    .in_photon_shadow(in_ch.data.photon_shadow),
    .capacity_limit(cap_r), .gather_sq_radius(rad_r),
    .res_accepted(out_ch.data.accepted), .res_class(out_ch.data.shadow_class)
  );

  // no new word while a result waits
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("input taken with result pending");
  // a rejected store result always reports class 0
  a_store_cls: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.data.accepted) |-> out_ch.data.shadow_class == CLS_LIT)
    else $error("rejected store with class");
  // accepted input leads to busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready) else $error("double accept");
endmodule

>>> tb/kd_tree_shadow_photon_query_test.sv
// Self-checking testbench for the kd-tree shadow photon query block.
// Depends on kdsp_pkg, kdsp_if and the kd_tree_shadow_photon_query top level.
module kd_tree_shadow_photon_query_test;
  import kdsp_pkg::*;

  typedef struct packed {
    logic                         operation;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic [AXIS_W-1:0]            split_axis;
    logic                         photon_shadow;
  } photon_word_t;

  typedef struct packed {
    logic       accepted;
    logic [1:0] shadow_class;
  } answer_word_t;

  localparam int      CYCLE_LIMIT = 8000000;
  localparam longint  RAD_MAX     = (64'd1 << RAD_W) - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic            cfg_psel = 1'b0;
  logic            cfg_penable = 1'b0;
  logic            cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [63:0]     cfg_pwdata = '0;
  logic [63:0]     cfg_prdata;
  logic            cfg_pready;

  kdsp_if #(.payload_t(photon_word_t)) in_ch (clk);
  kdsp_if #(.payload_t(answer_word_t)) out_ch (clk);

  kd_tree_shadow_photon_query dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #1 clk = ~clk;

  // Shadow copy of the block state
  longint     mem_x [STORE_DEPTH];
  longint     mem_y [STORE_DEPTH];
  longint     mem_z [STORE_DEPTH];
  int         mem_axis [STORE_DEPTH];
  bit         mem_shadow [STORE_DEPTH];
  int         stored_cnt;
  int         cap_limit;
  longint     sq_radius;

  photon_word_t word_queue[$];
  answer_word_t answer_queue[$];
  int           mismatches;
  int           cycle_cnt;

  function automatic int median_of(int lo, int hi);
    int n;
    int m;
    n = hi - lo + 1;
    m = 1;
    while (4 * m <= n) m += m;
    if (3 * m <= n) return m + m + lo - 1;
    return hi - m + 1;
  endfunction

  // Walk the stored photons and classify the query point
  function automatic logic [1:0] classify_point(longint qx, longint qy, longint qz);
    int     stk_lo [WALK_DEPTH];
    int     stk_hi [WALK_DEPTH];
    int     sp;
    int     lo;
    int     hi;
    int     md;
    int     ax;
    bit     lit;
    bit     shad;
    bit     busy;
    bit     moved;
    longint dx, dy, dz, sum_sq, d, d2;
    sp = 0; lo = 0; hi = stored_cnt - 1; lit = 0; shad = 0; busy = 1;
    while (busy) begin
      moved = 0;
      if (hi >= lo) begin
        md = median_of(lo, hi) % STORE_DEPTH;
        dx = qx - mem_x[md]; dy = qy - mem_y[md]; dz = qz - mem_z[md];
        sum_sq = dx * dx + dy * dy + dz * dz;
        if (sum_sq < sq_radius) begin
          if (mem_shadow[md]) shad = 1;
          else lit = 1;
        end
        if (shad && lit) break;
        ax = (mem_axis[md] > 2) ? 2 : mem_axis[md];
        d = (ax == 0) ? dx : (ax == 1) ? dy : dz;
        d2 = d * d;
        if (d2 > sq_radius) begin
          if (d <= 0) hi = md - 1;
          else lo = md + 1;
          moved = 1;
        end else if (d2 < sq_radius) begin
          if (sp < WALK_DEPTH) begin
            stk_lo[sp] = md + 1; stk_hi[sp] = hi; sp++;
          end
          hi = md - 1;
          moved = 1;
        end
      end
      if (!moved) begin
        if (sp == 0) busy = 0;
        else begin
          sp--; lo = stk_lo[sp]; hi = stk_hi[sp];
        end
      end
    end
    if (shad && lit) return CLS_MIXED;
    if (lit) return CLS_LIT;
    return CLS_SHADOW;
  endfunction

  // Apply one accepted word to the shadow state and queue its answer
  function automatic void predict_word(photon_word_t w);
    answer_word_t a;
    int lim;
    a.accepted = 1'b1;
    a.shadow_class = CLS_LIT;
    if (w.operation == OP_STORE) begin
      lim = (cap_limit < STORE_DEPTH) ? cap_limit : STORE_DEPTH;
      if (stored_cnt >= lim) a.accepted = 1'b0;
      else begin
        mem_x[stored_cnt] = longint'(w.pos_x);
        mem_y[stored_cnt] = longint'(w.pos_y);
        mem_z[stored_cnt] = longint'(w.pos_z);
        mem_axis[stored_cnt] = int'(w.split_axis);
        mem_shadow[stored_cnt] = w.photon_shadow;
        stored_cnt++;
      end
    end else begin
      a.shadow_class = classify_point(longint'(w.pos_x), longint'(w.pos_y),
                                      longint'(w.pos_z));
    end
    answer_queue = {answer_queue, a};
  endfunction

  // Input driver: bursts with random gaps
  int burst_left = 1;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_word(in_ch.data);
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (word_queue.size() > 0) begin
          in_ch.data <= word_queue.pop_front();
          in_ch.valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: stall pattern with one long hold-off
  int stall_mode = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (cycle_cnt % 256 == 0) stall_mode <= $urandom_range(0, 2);
      if (cycle_cnt == 6000) begin
        hold_left <= 600;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (stall_mode == 0) begin
        out_ch.ready <= 1'b1;
      end else if (stall_mode == 1) begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end else begin
        out_ch.ready <= ($urandom_range(0, 9) < 3);
      end
    end
  end

  // Result monitor: compare against the oldest expected answer
  always @(posedge clk) begin
    answer_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (answer_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: accepted=%0d class=%0d",
                   out_ch.data.accepted, out_ch.data.shadow_class);
      end else begin
        want = answer_queue.pop_front();
        if (out_ch.data.accepted !== want.accepted ||
            out_ch.data.shadow_class !== want.shadow_class) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: accepted exp %0d got %0d, class exp %0d got %0d",
                     want.accepted, out_ch.data.accepted,
                     want.shadow_class, out_ch.data.shadow_class);
        end
      end
    end
  end

  // Hang guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(logic [ADDR_W-1:0] addr, logic [63:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= addr; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (addr == ADDR_CAPACITY) cap_limit = int'(value & 64'h7FF);
    else sq_radius = value & RAD_MAX;
  endtask

  // Hold until every queued word is sent and answered
  task automatic drain();
    while (word_queue.size() > 0 || in_ch.valid || answer_queue.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_word(logic op, int x, int y, int z, int ax, bit sh);
    photon_word_t w;
    w.operation = op;
    w.pos_x = COORD_BITS'(x); w.pos_y = COORD_BITS'(y); w.pos_z = COORD_BITS'(z);
    w.split_axis = AXIS_W'(ax);
    w.photon_shadow = sh;
    word_queue = {word_queue, w};
  endtask

  function automatic int pick_coord(bit wide);
    if (wide) return $signed(16'($urandom));
    return $urandom_range(0, 400) - 200;
  endfunction

  task automatic add_random_word(bit allow_store);
    bit wide;
    wide = ($urandom_range(0, 4) == 0);
    add_word((allow_store && $urandom_range(0, 3) == 0) ? OP_STORE : OP_QUERY,
             pick_coord(wide), pick_coord(wide), pick_coord(wide),
             $urandom_range(0, 3), $urandom_range(0, 1));
  endtask

  initial begin
    longint radius_pick;
    stored_cnt = 0; cap_limit = 1024; sq_radius = 0;
    mismatches = 0; cycle_cnt = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Empty store and a zero capacity
    write_reg(ADDR_CAPACITY, 0);
    add_word(OP_QUERY, 0, 0, 0, 0, 0);
    add_word(OP_STORE, 5, 5, 5, 0, 1);
    drain();

    // Extreme photons, every axis code, full radius gives mixed
    write_reg(ADDR_CAPACITY, 1024);
    write_reg(ADDR_RADIUS, RAD_MAX);
    add_word(OP_STORE, 32767, 32767, 32767, 0, 0);
    add_word(OP_STORE, -32768, -32768, -32768, 1, 1);
    add_word(OP_STORE, 0, 0, 0, 2, 0);
    add_word(OP_STORE, 10, 0, 0, 3, 1);
    add_word(OP_QUERY, -32768, -32768, -32768, 0, 0);
    add_word(OP_QUERY, 32767, 32767, 32767, 0, 0);
    add_word(OP_QUERY, 0, -32768, 32767, 0, 0);
    drain();

    // Exactly equal distances, pure lit and pure shadow answers
    write_reg(ADDR_RADIUS, 100);
    add_word(OP_QUERY, 0, 0, 0, 0, 0);
    add_word(OP_QUERY, 10, 0, 0, 0, 0);
    add_word(OP_QUERY, 20, 0, 0, 0, 0);
    add_word(OP_QUERY, 3, 3, 3, 0, 0);
    add_word(OP_QUERY, 12, 1, 1, 0, 0);
    drain();
    write_reg(ADDR_RADIUS, 0);
    add_word(OP_QUERY, 0, 0, 0, 0, 0);
    drain();
    write_reg(ADDR_CAPACITY, 5);
    add_word(OP_STORE, 1, 1, 1, 1, 0);
    add_word(OP_STORE, 2, 2, 2, 2, 1);
    drain();

    // Random phases with varied radius and capacity
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: radius_pick = $urandom_range(0, 2500);
        1: radius_pick = $urandom_range(2500, 160000);
        2: radius_pick = (ph == 2) ? RAD_MAX : longint'($urandom) << 2;
        default: radius_pick = 0;
      endcase
      write_reg(ADDR_RADIUS, radius_pick);
      if (ph == 6) write_reg(ADDR_CAPACITY, stored_cnt + 4);
      else if (ph == 7) write_reg(ADDR_CAPACITY, 2047);
      else write_reg(ADDR_CAPACITY, 1024);
      for (int i = 0; i < 110; i++) add_random_word(1'b1);
      drain();
    end

    repeat (50) @(posedge clk);
    if (mismatches == 0 && answer_queue.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
